@@ rtl/kcb_pkg.sv @@
// Shared constants, types and command format of the keystroke capture buffer.
package kcb_pkg;

    // Store sizes: the line keeps LINE_DEPTH-1 characters, the bank BANK_DEPTH
    localparam int LINE_DEPTH  = 64;
    localparam int BANK_DEPTH  = 32;
    localparam int LINE_CAP    = LINE_DEPTH - 1;
    localparam int QUEUE_DEPTH = 2;

    // Field widths
    localparam int OP_W    = 2;
    localparam int PAGE_W  = 16;
    localparam int USAGE_W = 16;
    localparam int IDX_W   = 6;
    localparam int CHAR_W  = 7;
    localparam int CNT_W   = 6;

    // Derived widths
    localparam int LA_W   = $clog2(LINE_DEPTH);
    localparam int LC_W   = $clog2(LINE_CAP + 1);
    localparam int BA_W   = $clog2(BANK_DEPTH);
    localparam int BC_W   = $clog2(BANK_DEPTH + 1);
    localparam int LSUM_W = ((LA_W > IDX_W) ? LA_W : IDX_W) + 1;
    localparam int BSUM_W = ((BC_W > IDX_W) ? BC_W : IDX_W) + 1;
    localparam int QA_W   = $clog2(QUEUE_DEPTH);
    localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

    // Characters with special handling
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 7'h08;
    localparam logic [CHAR_W-1:0] CHAR_SPACE     = 7'h20;

    // Work handed from the decoder to the execution side
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_APPEND,
        CMD_BACKSPACE,
        CMD_CLEAR,
        CMD_READ_LINE,
        CMD_READ_BANK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [CHAR_W-1:0]   ch;
        logic [IDX_W-1:0]    index;
    } cmd_t;

    // Queue status seen by the two sides
    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

endpackage

@@ rtl/kcb_req_if.sv @@
// Request channel: one operation per transfer.
interface kcb_req_if
    import kcb_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [PAGE_W-1:0]   hid_page;
    logic [USAGE_W-1:0]  key_usage;
    logic                is_press;
    logic [IDX_W-1:0]    read_index;

    modport source (
        output valid, operation, hid_page, key_usage, is_press, read_index,
        input  ready
    );
    modport sink (
        input  valid, operation, hid_page, key_usage, is_press, read_index,
        output ready
    );
endinterface

@@ rtl/kcb_rsp_if.sv @@
// Response channel: one result per transfer.
interface kcb_rsp_if
    import kcb_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  mapped_char;
    logic [CNT_W-1:0]   line_length;
    logic [CNT_W-1:0]   bank_count;
    logic [CHAR_W-1:0]  read_data;

    modport source (
        output valid, mapped_char, line_length, bank_count, read_data,
        input  ready
    );
    modport sink (
        input  valid, mapped_char, line_length, bank_count, read_data,
        output ready
    );
endinterface

@@ rtl/kcb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module kcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/kcb_front.sv @@
// Front end: takes request transfers and decodes them into commands.
module kcb_front
    import kcb_pkg::*;
(
    kcb_req_if.sink         req,
    input  queue_status_t   q_status,
    output logic            push,
    output cmd_t            push_cmd
);

    typedef enum logic [OP_W-1:0] {
        OP_KEY       = 2'd0,
        OP_CLEAR     = 2'd1,
        OP_READ_LINE = 2'd2,
        OP_READ_BANK = 2'd3
    } op_t;

    // HID keyboard usage to ASCII; zero where there is no mapping
    function automatic logic [CHAR_W-1:0] decode_usage(input logic [USAGE_W-1:0] u);
        logic [CHAR_W-1:0] c;
        c = '0;
        unique case (u) inside
            [16'h0004:16'h001D]: c = CHAR_W'(u[CHAR_W-1:0] - 7'h04 + 7'h41);
            [16'h001E:16'h0026]: c = CHAR_W'(u[CHAR_W-1:0] - 7'h1E + 7'h31);
            16'h0027:            c = 7'h30;
            16'h0028, 16'h002C:  c = CHAR_SPACE;
            16'h002A:            c = CHAR_BACKSPACE;
            16'h002D:            c = 7'h2D;
            16'h002E:            c = 7'h3D;
            16'h002F:            c = 7'h5B;
            16'h0030:            c = 7'h5D;
            16'h0031:            c = 7'h5C;
            16'h0033:            c = 7'h3B;
            16'h0034:            c = 7'h27;
            16'h0035:            c = 7'h60;
            16'h0036:            c = 7'h2C;
            16'h0037:            c = 7'h2E;
            16'h0038:            c = 7'h2F;
            default:             c = '0;
        endcase
        return c;
    endfunction

    logic              page_ok;
    logic [CHAR_W-1:0] key_char;

    // Accept whenever the queue has room
    assign req.ready = ~q_status.full;
    assign push      = req.valid & ~q_status.full;

    assign page_ok  = (req.hid_page == 16'h0007) || (req.hid_page == 16'h0000);
    assign key_char = (req.is_press && page_ok) ? decode_usage(req.key_usage) : '0;

    // Classify the request
    always_comb
    begin
        push_cmd.kind  = CMD_NONE;
        push_cmd.ch    = '0;
        push_cmd.index = req.read_index;
        unique case (op_t'(req.operation))
            OP_KEY:
            begin
                push_cmd.ch = key_char;
                if (key_char == CHAR_BACKSPACE)
                begin
                    push_cmd.kind = CMD_BACKSPACE;
                end
                else if (key_char != '0)
                begin
                    push_cmd.kind = CMD_APPEND;
                end
            end
            OP_CLEAR:     push_cmd.kind = CMD_CLEAR;
            OP_READ_LINE: push_cmd.kind = CMD_READ_LINE;
            OP_READ_BANK: push_cmd.kind = CMD_READ_BANK;
            default:      push_cmd.kind = CMD_NONE;
        endcase
    end

endmodule

@@ rtl/kcb_queue.sv @@
// Short command queue between the decoder and the execution side.
module kcb_queue
    import kcb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cmd_t          push_cmd,
    input  logic          pop,
    output queue_status_t q_status,
    output cmd_t          head_cmd
);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [QA_W-1:0]  wr_ptr_reg;
    logic [QA_W-1:0]  wr_ptr_next;
    logic [QA_W-1:0]  rd_ptr_reg;
    logic [QA_W-1:0]  rd_ptr_next;
    logic [QC_W-1:0]  count_reg;
    logic [QC_W-1:0]  count_next;
    logic             do_pop;

    assign q_status.full      = (count_reg == QC_W'(QUEUE_DEPTH));
    assign q_status.not_empty = (count_reg != '0);
    assign head_cmd           = entry_reg[rd_ptr_reg];
    assign do_pop             = pop & q_status.not_empty;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, payload only
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/kcb_back.sv @@
// Back end: runs commands against the two ring stores and holds the result.
module kcb_back
    import kcb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  cmd_t          head_cmd,
    output logic          pop,
    kcb_rsp_if.source     rsp
);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    localparam logic [LC_W-1:0] LINE_CAP_C = LC_W'(LINE_CAP);
    localparam logic [BC_W-1:0] BANK_CAP_C = BC_W'(BANK_DEPTH);

    state_t            state_reg, state_next;
    logic [LA_W-1:0]   line_head_reg, line_head_next;
    logic [LC_W-1:0]   line_count_reg, line_count_next;
    logic [BA_W-1:0]   bank_head_reg, bank_head_next;
    logic [BC_W-1:0]   bank_fill_reg, bank_fill_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] mapped_reg, mapped_next;
    logic [CHAR_W-1:0] read_data_reg, read_data_next;
    logic              hit_reg, hit_next;
    logic              sel_bank_reg, sel_bank_next;

    logic              line_we, bank_we;
    logic [LA_W-1:0]   line_waddr, line_raddr;
    logic [BA_W-1:0]   bank_waddr, bank_raddr;
    logic [CHAR_W-1:0] line_rdata, bank_rdata;
    logic              take;

    // Ring index wrap: sums stay below twice the depth where it matters
    function automatic logic [LA_W-1:0] line_wrap(input logic [LSUM_W-1:0] s);
        logic [LSUM_W-1:0] r;
        r = (s >= LSUM_W'(LINE_DEPTH)) ? s - LSUM_W'(LINE_DEPTH) : s;
        return r[LA_W-1:0];
    endfunction

    function automatic logic [BA_W-1:0] bank_wrap(input logic [BSUM_W-1:0] s);
        logic [BSUM_W-1:0] r;
        r = (s >= BSUM_W'(BANK_DEPTH)) ? s - BSUM_W'(BANK_DEPTH) : s;
        return r[BA_W-1:0];
    endfunction

    kcb_ram #(.WIDTH(CHAR_W), .DEPTH(LINE_DEPTH)) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (head_cmd.ch),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    kcb_ram #(.WIDTH(CHAR_W), .DEPTH(BANK_DEPTH)) u_bank_ram (
        .clk   (clk),
        .we    (bank_we),
        .waddr (bank_waddr),
        .wdata (head_cmd.ch),
        .raddr (bank_raddr),
        .rdata (bank_rdata)
    );

    // Take a command only when the result register is free by the next edge
    assign take = (state_reg == ST_IDLE) && q_status.not_empty &&
                  (!out_valid_reg || rsp.ready);
    assign pop  = take;

    // Store addresses
    assign line_waddr = line_wrap(LSUM_W'(line_head_reg) + LSUM_W'(line_count_reg));
    assign bank_waddr = bank_wrap(BSUM_W'(bank_head_reg) + BSUM_W'(bank_fill_reg));
    assign line_raddr = line_wrap(LSUM_W'(line_head_reg) + LSUM_W'(head_cmd.index));
    assign bank_raddr = bank_wrap(BSUM_W'(bank_head_reg) + BSUM_W'(head_cmd.index));

    // Command execution
    always_comb
    begin
        state_next      = state_reg;
        line_head_next  = line_head_reg;
        line_count_next = line_count_reg;
        bank_head_next  = bank_head_reg;
        bank_fill_next  = bank_fill_reg;
        out_valid_next  = out_valid_reg;
        mapped_next     = mapped_reg;
        read_data_next  = read_data_reg;
        hit_next        = hit_reg;
        sel_bank_next   = sel_bank_reg;
        line_we         = 1'b0;
        bank_we         = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    mapped_next    = head_cmd.ch;
                    read_data_next = '0;
                    out_valid_next = 1'b1;
                    case (head_cmd.kind)
                        CMD_APPEND:
                        begin
                            line_we = 1'b1;
                            if (line_count_reg < LINE_CAP_C)
                            begin
                                line_count_next = line_count_reg + 1'b1;
                            end
                            else
                            begin
                                line_head_next = line_wrap(LSUM_W'(line_head_reg) + 1'b1);
                            end
                            // Space goes to the line only
                            if (head_cmd.ch > CHAR_SPACE)
                            begin
                                bank_we = 1'b1;
                                if (bank_fill_reg < BANK_CAP_C)
                                begin
                                    bank_fill_next = bank_fill_reg + 1'b1;
                                end
                                else
                                begin
                                    bank_head_next =
                                        bank_wrap(BSUM_W'(bank_head_reg) + 1'b1);
                                end
                            end
                        end
                        CMD_BACKSPACE:
                        begin
                            if (line_count_reg != '0)
                            begin
                                line_count_next = line_count_reg - 1'b1;
                            end
                            if (bank_fill_reg != '0)
                            begin
                                bank_fill_next = bank_fill_reg - 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            line_head_next  = '0;
                            line_count_next = '0;
                            bank_head_next  = '0;
                            bank_fill_next  = '0;
                        end
                        CMD_READ_LINE:
                        begin
                            out_valid_next = 1'b0;
                            sel_bank_next  = 1'b0;
                            hit_next       = LSUM_W'(head_cmd.index) < LSUM_W'(line_count_reg);
                            state_next     = ST_READ;
                        end
                        CMD_READ_BANK:
                        begin
                            out_valid_next = 1'b0;
                            sel_bank_next  = 1'b1;
                            hit_next       = BSUM_W'(head_cmd.index) < BSUM_W'(bank_fill_reg);
                            state_next     = ST_READ;
                        end
                        default:
                        begin
                            mapped_next = '0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // Read data from the store is valid now
                out_valid_next = 1'b1;
                read_data_next = !hit_reg ? '0 : (sel_bank_reg ? bank_rdata : line_rdata);
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            line_head_reg  <= '0;
            line_count_reg <= '0;
            bank_head_reg  <= '0;
            bank_fill_reg  <= '0;
            out_valid_reg  <= 1'b0;
            mapped_reg     <= '0;
            read_data_reg  <= '0;
            hit_reg        <= 1'b0;
            sel_bank_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            line_head_reg  <= line_head_next;
            line_count_reg <= line_count_next;
            bank_head_reg  <= bank_head_next;
            bank_fill_reg  <= bank_fill_next;
            out_valid_reg  <= out_valid_next;
            mapped_reg     <= mapped_next;
            read_data_reg  <= read_data_next;
            hit_reg        <= hit_next;
            sel_bank_reg   <= sel_bank_next;
        end
    end

    // Counts change only when a new result is loaded, so they are reported live
    assign rsp.valid       = out_valid_reg;
    assign rsp.mapped_char = mapped_reg;
    assign rsp.read_data   = read_data_reg;
    assign rsp.line_length = CNT_W'(line_count_reg);
    assign rsp.bank_count  = CNT_W'(bank_fill_reg);

endmodule

@@ rtl/keystroke_capture_buffer_top.sv @@
// Top level of the keystroke capture buffer.
// Translates HID keyboard presses (usage page 7 or 0) to ASCII and keeps a
// line of up to LINE_DEPTH-1 characters and a bank of up to BANK_DEPTH
// non-space characters, each a ring in its own RAM that drops its oldest
// entry when full; backspace trims both, clear empties both, and reads
// return the entry at read_index counted from the oldest, or 0 beyond the
// count. Every request gives exactly one response; no clearing pass is
// needed after reset. A decoder accepts requests into a two-entry
// command queue; the execution side takes one command at a time: key
// events and clears load the result on take, reads pass a read state
// for the registered RAM read. The queue accepts while a result waits.
module keystroke_capture_buffer_top
    import kcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    kcb_req_if.sink     req,
    kcb_rsp_if.source   rsp
);

    queue_status_t q_status;
    logic          push;
    cmd_t          push_cmd;
    logic          pop;
    cmd_t          head_cmd;

    // Decode and accept
    kcb_front u_front (
        .req      (req),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Decoupling queue
    kcb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .q_status (q_status),
        .head_cmd (head_cmd)
    );

    // Execution and result register
    kcb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head_cmd (head_cmd),
        .pop      (pop),
        .rsp      (rsp)
    );

endmodule
